// ===== rtl/core/cppa_pkg.sv =====
`timescale 1ns / 1ps

package cppa_pkg;

    localparam int FRAME_W    = 20;
    localparam int RUN_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_POOL_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUN      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_IN_POOL = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_COUNT  = 3'd4;

endpackage

// ===== rtl/core/contiguous_page_pool_allocator_core.sv =====
`timescale 1ns / 1ps

// First-fit allocator for a pool of PAGE_COUNT pages, one used mark per page held in a
// single-port-write, single-port-read memory that is walked one mark per cycle. After reset
// the block clears every mark in the memory before s_tready first rises; configuration
// writes are taken throughout. A zero count, an allocate into a full pool and a free outside
// the pool go from the accept straight to the answer state. An allocate scans from the
// lowest free page, then marks the run, and if the run started at the lowest free page
// scans on past the end of the run for the next free page. A free clears run_length marks,
// clipped at the pool end. One request is worked at a time; the next is accepted while the
// previous result still waits on the m_ side, and the answer cycle holds until it drains.
module contiguous_page_pool_allocator_core #(
    parameter int PAGE_COUNT = 128
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cppa_pkg::FRAME_W-1:0]   cfg_wr_data,   // pool_base_frame
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cppa_pkg::S_TDATA_W-1:0] s_tdata,       // [7:0] run_length, [27:8] frame_in
    input  logic [0:0]                     s_tuser,       // [0] command
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cppa_pkg::M_TDATA_W-1:0] m_tdata        // [2:0] status, [22:3] frame_out
);

    localparam int IDX_W = $clog2(PAGE_COUNT);
    localparam int CNT_W = $clog2(PAGE_COUNT + 1);
    localparam logic [CNT_W-1:0] PAGES     = CNT_W'(PAGE_COUNT);
    localparam logic [CNT_W-1:0] LAST_PAGE = CNT_W'(PAGE_COUNT - 1);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_MARK  = 7'b0001000,
        ST_FIND  = 7'b0010000,
        ST_FREE  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                iss_reg, iss_next;
    logic [IDX_W-1:0]                chk_reg, chk_next;
    logic                            pend_reg, pend_next;
    logic [cppa_pkg::RUN_W-1:0]      run_reg, run_next;
    logic [IDX_W-1:0]                start_reg, start_next;
    logic [cppa_pkg::RUN_W-1:0]      n_reg, n_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [cppa_pkg::RUN_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]                lowest_reg, lowest_next;
    logic                            full_reg, full_next;
    logic [cppa_pkg::FRAME_W-1:0]    base_reg, base_next;
    logic [cppa_pkg::STATUS_W-1:0]   st_reg, st_next;
    logic [cppa_pkg::FRAME_W-1:0]    fr_reg, fr_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [cppa_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [cppa_pkg::FRAME_W-1:0]    m_frame_reg, m_frame_next;

    // page mark memory
    logic                            page_used [PAGE_COUNT];
    logic                            rd_bit_reg;
    logic                            mem_we;
    logic [IDX_W-1:0]                mem_wa;
    logic                            mem_wd;

    logic                            in_cmd;
    logic [cppa_pkg::RUN_W-1:0]      in_run;
    logic [cppa_pkg::FRAME_W-1:0]    in_frame;
    logic [cppa_pkg::FRAME_W-1:0]    free_off;
    logic                            in_pool;
    logic                            issue;
    logic                            run_hit;

    assign in_cmd   = s_tuser[0];
    assign in_run   = s_tdata[cppa_pkg::RUN_W-1:0];
    assign in_frame = s_tdata[cppa_pkg::RUN_W +: cppa_pkg::FRAME_W];
    assign free_off = in_frame - base_reg;
    assign in_pool  = free_off < cppa_pkg::FRAME_W'(PAGE_COUNT);
    assign issue    = iss_reg != PAGES;
    assign run_hit  = ({1'b0, run_reg} + 9'd1) == {1'b0, n_reg};

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_frame_reg, m_status_reg};

    always_comb begin
        state_next    = state_reg;
        iss_next      = iss_reg;
        chk_next      = chk_reg;
        pend_next     = pend_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        lowest_next   = lowest_reg;
        full_next     = full_reg;
        base_next     = cfg_wr_en ? cfg_wr_data : base_reg;
        st_next       = st_reg;
        fr_next       = fr_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_status_next = m_status_reg;
        m_frame_next  = m_frame_reg;
        mem_we        = 1'b0;
        mem_wa        = idx_reg[IDX_W-1:0];
        mem_wd        = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = iss_reg[IDX_W-1:0];
                iss_next = iss_reg + 1'b1;
                if (iss_reg == LAST_PAGE) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    n_next  = in_run;
                    st_next = cppa_pkg::STATUS_OK;
                    fr_next = '0;
                    if (in_run == '0) begin
                        st_next    = cppa_pkg::STATUS_ZERO_COUNT;
                        state_next = ST_DONE;
                    end else if (in_cmd == cppa_pkg::CMD_ALLOC) begin
                        if (full_reg) begin
                            st_next    = cppa_pkg::STATUS_POOL_FULL;
                            state_next = ST_DONE;
                        end else begin
                            iss_next   = CNT_W'(lowest_reg);
                            pend_next  = 1'b0;
                            run_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end else if (!in_pool) begin
                        st_next    = cppa_pkg::STATUS_NOT_IN_POOL;
                        state_next = ST_DONE;
                    end else begin
                        idx_next  = CNT_W'(free_off[IDX_W-1:0]);
                        cnt_next  = in_run;
                        full_next = 1'b0;
                        if (full_reg || (free_off[IDX_W-1:0] < lowest_reg)) begin
                            lowest_next = free_off[IDX_W-1:0];
                        end
                        state_next = ST_FREE;
                    end
                end
            end
            ST_SCAN: begin
                // read one mark ahead; chk_reg names the mark in rd_bit_reg
                iss_next  = iss_reg + CNT_W'(issue);
                pend_next = issue;
                chk_next  = iss_reg[IDX_W-1:0];
                if (pend_reg) begin
                    if (rd_bit_reg) begin
                        run_next = '0;
                    end else begin
                        if (run_reg == '0) begin
                            start_next = chk_reg;
                        end
                        if (run_hit) begin
                            idx_next   = CNT_W'((run_reg == '0) ? chk_reg : start_reg);
                            cnt_next   = n_reg;
                            state_next = ST_MARK;
                        end else begin
                            run_next = run_reg + 1'b1;
                        end
                    end
                end else if (!issue) begin
                    st_next    = cppa_pkg::STATUS_NO_RUN;
                    state_next = ST_DONE;
                end
            end
            ST_MARK: begin
                mem_we   = 1'b1;
                mem_wd   = 1'b1;
                idx_next = idx_reg + 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == 8'd1) begin
                    fr_next = base_reg + cppa_pkg::FRAME_W'(start_reg);
                    if (start_reg == lowest_reg) begin
                        // lowest free page was taken: look past the new run
                        iss_next   = idx_reg + 1'b1;
                        pend_next  = 1'b0;
                        state_next = ST_FIND;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FIND: begin
                iss_next  = iss_reg + CNT_W'(issue);
                pend_next = issue;
                chk_next  = iss_reg[IDX_W-1:0];
                if (pend_reg) begin
                    if (!rd_bit_reg) begin
                        lowest_next = chk_reg;
                        state_next  = ST_DONE;
                    end
                end else if (!issue) begin
                    full_next   = 1'b1;
                    lowest_next = '0;
                    state_next  = ST_DONE;
                end
            end
            ST_FREE: begin
                if ((cnt_reg != '0) && (idx_reg != PAGES)) begin
                    mem_we   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = st_reg;
                    m_frame_next  = fr_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            iss_reg      <= '0;
            pend_reg     <= 1'b0;
            lowest_reg   <= '0;
            full_reg     <= 1'b0;
            base_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            iss_reg      <= iss_next;
            pend_reg     <= pend_next;
            lowest_reg   <= lowest_next;
            full_reg     <= full_next;
            base_reg     <= base_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_reg      <= chk_next;
        run_reg      <= run_next;
        start_reg    <= start_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        st_reg       <= st_next;
        fr_reg       <= fr_next;
        m_status_reg <= m_status_next;
        m_frame_reg  <= m_frame_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            page_used[mem_wa] <= mem_wd;
        end
        rd_bit_reg <= page_used[iss_reg[IDX_W-1:0]];
    end

    a_full_lowest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        full_reg |-> (lowest_reg == '0))
        else $error("pool full with nonzero lowest free index");

    a_fail_frame_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_status_reg != cppa_pkg::STATUS_OK)) |-> (m_frame_reg == '0))
        else $error("failed request returned a nonzero frame");

    a_zero_count_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (in_run == '0)) |=> (state_reg == ST_DONE))
        else $error("zero count request did not answer at once");

    a_scan_run_short: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (run_reg < n_reg))
        else $error("scan run counter reached the request length");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) || (state_reg == ST_FIND)) |-> (iss_reg <= PAGES))
        else $error("scan read address ran past the pool");

endmodule

// ===== verif/tb_contiguous_page_pool_allocator_core.sv =====
`timescale 1ns / 1ps

module tb_contiguous_page_pool_allocator_core;

    localparam int PAGES          = 128;
    localparam int DIR_ROWS       = 24;
    localparam int PHASES         = 5;
    localparam int WORDS_PER_PHASE = 270;
    localparam int HOLD_AT        = 420;
    localparam int HOLD_CYCLES    = 600;

    typedef struct packed {
        logic [cppa_pkg::STATUS_W-1:0] status;
        logic [cppa_pkg::FRAME_W-1:0]  frame;
    } reply_t;

    typedef struct packed {
        logic                          cmd;
        logic [cppa_pkg::RUN_W-1:0]    len;
        logic [cppa_pkg::FRAME_W-1:0]  frame;
        logic                          typed;
        logic [cppa_pkg::STATUS_W-1:0] status;
        logic [cppa_pkg::FRAME_W-1:0]  frame_out;
    } dir_row_t;

    logic                           aclk        = 1'b0;
    logic                           aresetn     = 1'b0;
    logic                           cfg_wr_en   = 1'b0;
    logic [cppa_pkg::FRAME_W-1:0]   cfg_wr_data = '0;
    logic                           s_tvalid    = 1'b0;
    logic                           s_tready;
    logic [cppa_pkg::S_TDATA_W-1:0] s_tdata     = '0;
    logic [0:0]                     s_tuser     = '0;
    logic                           m_tvalid;
    logic                           m_tready    = 1'b0;
    logic [cppa_pkg::M_TDATA_W-1:0] m_tdata;

    // pool state as the block should hold it
    bit                           page_used [PAGES];
    int                           lowest_free;
    bit                           pool_full;
    logic [cppa_pkg::FRAME_W-1:0] pool_base;

    reply_t owed_replies [$];
    int     error_count;
    int     words_sent;
    int     burst_left;

    // receiver stall pattern
    int hold_left;
    bit hold_done;
    int seg_left;
    int stall_pct;

    contiguous_page_pool_allocator_core #(
        .PAGE_COUNT(PAGES)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #10 aclk = ~aclk;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("ERROR at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    task automatic predict_reply(input logic cmd, input logic [cppa_pkg::RUN_W-1:0] len,
                                 input logic [cppa_pkg::FRAME_W-1:0] frame_in,
                                 output reply_t r);
        int n;
        int idx;
        int start;
        int run;
        logic [cppa_pkg::FRAME_W-1:0] off;
        n = int'(len);
        r.status = cppa_pkg::STATUS_OK;
        r.frame  = '0;
        if (n == 0) begin
            r.status = cppa_pkg::STATUS_ZERO_COUNT;
        end else if (cmd == cppa_pkg::CMD_ALLOC) begin
            if (pool_full) begin
                r.status = cppa_pkg::STATUS_POOL_FULL;
            end else begin
                start = lowest_free;
                run   = 0;
                // a used page restarts the run; the first free page after it counts
                for (idx = lowest_free; idx < PAGES && run < n; idx++) begin
                    if (page_used[idx]) begin
                        run = 0;
                    end else begin
                        if (run == 0)
                            start = idx;
                        run++;
                    end
                end
                if (run < n) begin
                    r.status = cppa_pkg::STATUS_NO_RUN;
                end else begin
                    for (idx = start; idx < start + n && idx < PAGES; idx++)
                        page_used[idx] = 1'b1;
                    pool_full   = 1'b1;
                    lowest_free = 0;
                    for (idx = PAGES - 1; idx >= 0; idx--) begin
                        if (!page_used[idx]) begin
                            lowest_free = idx;
                            pool_full   = 1'b0;
                        end
                    end
                    r.frame = pool_base + cppa_pkg::FRAME_W'(start);
                end
            end
        end else begin
            off = frame_in - pool_base;
            if (off >= PAGES) begin
                r.status = cppa_pkg::STATUS_NOT_IN_POOL;
            end else begin
                for (idx = int'(off); idx < int'(off) + n && idx < PAGES; idx++)
                    page_used[idx] = 1'b0;
                if (pool_full || int'(off) < lowest_free)
                    lowest_free = int'(off);
                pool_full = 1'b0;
            end
        end
    endtask

    // offer one request word; bursts with random gaps between them
    task automatic offer_word(input logic cmd, input logic [cppa_pkg::RUN_W-1:0] len,
                              input logic [cppa_pkg::FRAME_W-1:0] frame, input bit typed,
                              input reply_t typed_reply);
        int gap;
        reply_t r;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(60, 200);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, 12);
            end
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cppa_pkg::S_TDATA_W - cppa_pkg::FRAME_W - cppa_pkg::RUN_W){1'b0}},
                     frame, len};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        predict_reply(cmd, len, frame, r);
        owed_replies.push_back(typed ? typed_reply : r);
    endtask

    task automatic drain_replies();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (owed_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic write_pool_base(input logic [cppa_pkg::FRAME_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        pool_base = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic offer_random_word(input int alloc_pct);
        logic                         cmd;
        logic [cppa_pkg::RUN_W-1:0]   len;
        logic [cppa_pkg::FRAME_W-1:0] frame;
        int                           pick;
        cmd   = ($urandom_range(0, 99) < alloc_pct) ? cppa_pkg::CMD_ALLOC : cppa_pkg::CMD_FREE;
        frame = cppa_pkg::FRAME_W'($urandom_range(0, 20'hFFFFF));
        pick  = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 3) begin
            len = '0;
        end else if (cmd == cppa_pkg::CMD_ALLOC) begin
            if (pick < 80)
                len = cppa_pkg::RUN_W'($urandom_range(1, 6));
            else if (pick < 95)
                len = cppa_pkg::RUN_W'($urandom_range(7, 128));
            else
                len = cppa_pkg::RUN_W'($urandom_range(129, 255));
        end else begin
            if (pick < 70)
                len = cppa_pkg::RUN_W'($urandom_range(1, 8));
            else if (pick < 95)
                len = cppa_pkg::RUN_W'($urandom_range(9, 64));
            else
                len = cppa_pkg::RUN_W'($urandom_range(65, 255));
            pick = $urandom_range(0, 99);
            if (pick < 85)
                frame = pool_base + cppa_pkg::FRAME_W'($urandom_range(0, PAGES - 1));
            else if (pick < 90)
                frame = pool_base + cppa_pkg::FRAME_W'($urandom_range(PAGES, PAGES + 3));
            else if (pick < 93)
                frame = pool_base - cppa_pkg::FRAME_W'($urandom_range(1, 3));
        end
        offer_word(cmd, len, frame, 1'b0, '0);
    endtask

    // receiver: segments with their own stall rate, one long hold-off
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && words_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(16, 160);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_replies.size() == 0) begin
                report_mismatch("unexpected result word", 32'(m_tdata), 0);
            end else begin
                want = owed_replies.pop_front();
                if (m_tdata[cppa_pkg::STATUS_W-1:0] !== want.status)
                    report_mismatch("status", 32'(m_tdata[cppa_pkg::STATUS_W-1:0]),
                                    32'(want.status));
                if (m_tdata[cppa_pkg::STATUS_W +: cppa_pkg::FRAME_W] !== want.frame)
                    report_mismatch("frame_out",
                                    32'(m_tdata[cppa_pkg::STATUS_W +: cppa_pkg::FRAME_W]),
                                    32'(want.frame));
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        dir_row_t                     dir_rows [DIR_ROWS];
        logic [cppa_pkg::FRAME_W-1:0] phase_base [PHASES];
        int                           alloc_mix [PHASES];
        int                           i;
        int                           ph;

        dir_rows = '{
            '{cppa_pkg::CMD_ALLOC, 8'd0,   20'h12345, 1'b1, cppa_pkg::STATUS_ZERO_COUNT, 20'h0},
            '{cppa_pkg::CMD_FREE,  8'd0,   20'h00005, 1'b1, cppa_pkg::STATUS_ZERO_COUNT, 20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd1,   20'hFFFFF, 1'b1, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd255, 20'h00000, 1'b1, cppa_pkg::STATUS_NO_RUN,     20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd129, 20'h00000, 1'b1, cppa_pkg::STATUS_NO_RUN,     20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd127, 20'hABCDE, 1'b1, cppa_pkg::STATUS_OK,         20'h1},
            '{cppa_pkg::CMD_ALLOC, 8'd1,   20'h00000, 1'b1, cppa_pkg::STATUS_POOL_FULL,  20'h0},
            '{cppa_pkg::CMD_FREE,  8'd1,   20'h00080, 1'b1, cppa_pkg::STATUS_NOT_IN_POOL,
              20'h0},
            '{cppa_pkg::CMD_FREE,  8'd1,   20'hFFFFF, 1'b1, cppa_pkg::STATUS_NOT_IN_POOL,
              20'h0},
            '{cppa_pkg::CMD_FREE,  8'd255, 20'h0007F, 1'b1, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd2,   20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd1,   20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_FREE,  8'd4,   20'h0000A, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_FREE,  8'd3,   20'h00014, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd3,   20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            // run of one at 13 breaks, first fit restarts at 20
            '{cppa_pkg::CMD_ALLOC, 8'd2,   20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_FREE,  8'd128, 20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd128, 20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_FREE,  8'd1,   20'h00040, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_FREE,  8'd1,   20'h00003, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd2,   20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd1,   20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_ALLOC, 8'd1,   20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0},
            '{cppa_pkg::CMD_FREE,  8'd128, 20'h00000, 1'b0, cppa_pkg::STATUS_OK,         20'h0}
        };
        phase_base = '{20'hFFFFF, 20'h0, 20'hFFFC0, 20'h00000, 20'h7FFC1};
        phase_base[1] = cppa_pkg::FRAME_W'($urandom_range(0, 20'hFFFFF));
        alloc_mix  = '{70, 50, 80, 35, 60};

        for (i = 0; i < PAGES; i++)
            page_used[i] = 1'b0;
        lowest_free = 0;
        pool_full   = 1'b0;
        pool_base   = '0;
        error_count = 0;
        words_sent  = 0;
        burst_left  = 0;
        hold_left   = 0;
        hold_done   = 1'b0;
        seg_left    = 0;
        stall_pct   = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_pool_base('0);
        for (i = 0; i < DIR_ROWS; i++)
            offer_word(dir_rows[i].cmd, dir_rows[i].len, dir_rows[i].frame, dir_rows[i].typed,
                       '{dir_rows[i].status, dir_rows[i].frame_out});
        drain_replies();

        for (ph = 0; ph < PHASES; ph++) begin
            write_pool_base(phase_base[ph]);
            for (i = 0; i < WORDS_PER_PHASE; i++)
                offer_random_word(alloc_mix[ph]);
            drain_replies();
        end

        // settle time before the verdict
        repeat (3 * PAGES + 20) @(posedge aclk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
